// ----- design/lcpu_pkg.sv -----
// Shared types and constants for the lattice contact-process update block.
// No dependencies.
package lcpu_pkg;

    localparam int SIDE_DEFAULT = 128;

    localparam int COORD_IN_W  = 7;
    localparam int FRAC_W      = 16;
    localparam int THR_W       = 17;
    localparam int SWEEP_W     = 15;
    localparam int SWEEP_CNT_W = 14;
    localparam int POP_W       = 15;
    localparam int TOTAL_W     = 32;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [THR_W-1:0]   DEATH_RESET  = 17'd39649;
    localparam logic [THR_W-1:0]   GROWTH_RESET = 17'd65536;
    localparam logic [SWEEP_W-1:0] SWEEP_RESET  = 15'd16384;
    localparam logic [SWEEP_W-1:0] SWEEP_MAX    = 15'd16384;
    localparam int                 SEED_COUNT   = 4;

    localparam logic [1:0] REG_DEATH  = 2'd0;
    localparam logic [1:0] REG_GROWTH = 2'd1;
    localparam logic [1:0] REG_SWEEP  = 2'd2;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_ABOVE = 2'd2;
    localparam logic [1:0] DIR_BELOW = 2'd3;

    typedef struct packed {
        logic [COORD_IN_W-1:0] site_x;
        logic [COORD_IN_W-1:0] site_y;
        logic [1:0]            direction;
        logic [FRAC_W-1:0]     random_fraction;
    } lcpu_site_t;

    typedef struct packed {
        logic               new_value;
        logic [POP_W-1:0]   population;
        logic               sweep_end;
        logic               reseeded;
        logic [TOTAL_W-1:0] reset_total;
    } lcpu_result_t;

    typedef struct packed {
        logic [THR_W-1:0]   death_threshold;
        logic [THR_W-1:0]   growth_threshold;
        logic [SWEEP_W-1:0] sweep_length;
    } lcpu_cfg_t;

    // centre 2x2 block membership of a cell
    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } lcpu_ctr_t;

endpackage

// ----- design/lcpu_cfg_regs.sv -----
// APB-style configuration registers: thresholds and sweep length.
// Depends on lcpu_pkg.
module lcpu_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcpu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lcpu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lcpu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output lcpu_pkg::lcpu_cfg_t               cfg
);
    import lcpu_pkg::*;

    logic [THR_W-1:0]   death_reg;
    logic [THR_W-1:0]   growth_reg;
    logic [SWEEP_W-1:0] sweep_reg;
    logic [1:0]         reg_idx;
    logic               wr_fire;

    assign reg_idx = paddr[3:2];
    assign wr_fire = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            death_reg  <= DEATH_RESET;
            growth_reg <= GROWTH_RESET;
            sweep_reg  <= SWEEP_RESET;
        end
        else if (wr_fire)
        begin
            unique case (reg_idx)
                REG_DEATH:  death_reg  <= pwdata[THR_W-1:0];
                REG_GROWTH: growth_reg <= pwdata[THR_W-1:0];
                REG_SWEEP:  sweep_reg  <= pwdata[SWEEP_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEATH:  prdata = APB_DATA_W'(death_reg);
            REG_GROWTH: prdata = APB_DATA_W'(growth_reg);
            REG_SWEEP:  prdata = APB_DATA_W'(sweep_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.death_threshold  = death_reg;
    assign cfg.growth_threshold = growth_reg;
    assign cfg.sweep_length     = sweep_reg;

endmodule

// ----- design/lcpu_lattice_mem.sv -----
// Occupancy bit memory: two copies written together, one read port each.
// No dependencies; its parameters come from the top.
module lcpu_lattice_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic          rd_data_a,
    output logic          rd_data_b
);
    logic mem_a_reg [DEPTH];
    logic mem_b_reg [DEPTH];
    logic rd_data_a_reg;
    logic rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a_reg[wr_addr] <= wr_data;
            mem_b_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem_a_reg[rd_addr_a];
            rd_data_b_reg <= mem_b_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- design/lcpu_site_decode.sv -----
// Site decode: wraps coordinates, finds the neighbour, forms cell addresses and centre flags.
// Depends on lcpu_pkg.
module lcpu_site_decode #(
    parameter int SIDE = lcpu_pkg::SIDE_DEFAULT,
    parameter int CW   = $clog2(SIDE),
    parameter int AW   = $clog2(SIDE * SIDE)
) (
    input  lcpu_pkg::lcpu_site_t site,
    output logic [AW-1:0]        here_addr,
    output logic [AW-1:0]        nb_addr,
    output lcpu_pkg::lcpu_ctr_t  here_ctr,
    output lcpu_pkg::lcpu_ctr_t  nb_ctr
);
    import lcpu_pkg::*;

    localparam int            RW     = CW + 8;
    localparam logic [CW-1:0] CTR_LO = CW'(SIDE / 2);
    localparam logic [CW-1:0] CTR_HI = CW'(SIDE / 2 + 1);
    localparam logic [CW-1:0] MAX_C  = CW'(SIDE - 1);

    // restoring reduction modulo SIDE, one shifted multiple per step
    function automatic logic [CW-1:0] wrap_coord(input logic [COORD_IN_W-1:0] v);
        logic [RW-1:0] r;
        r = RW'(v);
        for (int k = COORD_IN_W - 1; k >= 0; k--)
        begin
            if (r >= (RW'(SIDE) << k))
                r = r - (RW'(SIDE) << k);
        end
        return r[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] cx,
                                              input logic [CW-1:0] cy);
        return AW'(cy) * AW'(SIDE) + AW'(cx);
    endfunction

    function automatic lcpu_ctr_t ctr_of(input logic [CW-1:0] cx,
                                         input logic [CW-1:0] cy);
        lcpu_ctr_t c;
        c.hit = (cx == CTR_LO || cx == CTR_HI) && (cy == CTR_LO || cy == CTR_HI);
        c.idx = {cy == CTR_HI, cx == CTR_HI};
        return c;
    endfunction

    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;

    assign x = wrap_coord(site.site_x);
    assign y = wrap_coord(site.site_y);

    always_comb
    begin
        nx = x;
        ny = y;
        case (site.direction)
            DIR_LEFT:  nx = (x == '0) ? MAX_C : x - CW'(1);
            DIR_RIGHT: nx = (x == MAX_C) ? '0 : x + CW'(1);
            DIR_ABOVE: ny = (y == '0) ? MAX_C : y - CW'(1);
            default:   ny = (y == MAX_C) ? '0 : y + CW'(1);
        endcase
    end

    assign here_addr = addr_of(x, y);
    assign nb_addr   = addr_of(nx, ny);
    assign here_ctr  = ctr_of(x, y);
    assign nb_ctr    = ctr_of(nx, ny);

endmodule

// ----- design/lattice_contact_process_update.sv -----
// Top level of the lattice contact-process update block: update pipeline,
// counters and centre cells. Depends on lcpu_pkg, lcpu_cfg_regs,
// lcpu_site_decode and lcpu_lattice_mem.
//
//   port group     | direction | handshake              | payload
//   site_*         | in        | site_valid/site_ready  | site_item (lcpu_site_t)
//   result_*       | out       | result_valid/ready     | result_item (lcpu_result_t)
//   p* (APB)       | in/out    | psel/penable, pready=1 | pwdata/prdata, 32 bits
//
// One item per cycle sustained while results are taken; each item goes from
// the memory read into the update stage, then into the result register.
// After reset the memory is swept to zero, one cell per cycle, SIDE*SIDE
// cells in all; site_ready stays low during that sweep.
// The centre 2x2 block lives in flip-flops, so a reseed needs no memory writes.
// A stalled result holds the update stage, which holds site_ready low.
module lattice_contact_process_update #(
    parameter int SIDE = lcpu_pkg::SIDE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              site_valid,
    output logic                              site_ready,
    input  lcpu_pkg::lcpu_site_t              site_item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output lcpu_pkg::lcpu_result_t            result_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lcpu_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lcpu_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lcpu_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import lcpu_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);

    lcpu_cfg_t cfg;

    lcpu_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [AW-1:0] here_addr;
    logic [AW-1:0] nb_addr;
    lcpu_ctr_t     here_ctr;
    lcpu_ctr_t     nb_ctr;

    lcpu_site_decode #(
        .SIDE (SIDE),
        .CW   (CW),
        .AW   (AW)
    ) u_decode (
        .site      (site_item),
        .here_addr (here_addr),
        .nb_addr   (nb_addr),
        .here_ctr  (here_ctr),
        .nb_ctr    (nb_ctr)
    );

    // control state
    logic               clr_active_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               s1_valid_reg;
    logic               result_valid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SWEEP_CNT_W-1:0] sweep_reg;
    logic [SWEEP_CNT_W-1:0] sweep_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [3:0]         centre_reg;
    logic [3:0]         centre_next;

    // update stage payload
    logic [AW-1:0]      s1_addr_reg;
    lcpu_ctr_t          s1_ctr_reg;
    lcpu_ctr_t          s1_nb_ctr_reg;
    logic [FRAC_W-1:0]  s1_frac_reg;
    logic               s1_fwd_here_reg;
    logic               s1_fwd_here_val_reg;
    logic               s1_fwd_nb_reg;
    logic               s1_fwd_nb_val_reg;
    lcpu_result_t       result_reg;

    logic accept;
    logic adv;
    logic s1_fire;
    logic rd_here;
    logic rd_nb;
    logic cur_here;
    logic cur_nb;
    logic die;
    logic grow;
    logic new_val;
    logic sweep_end;
    logic reseed;
    logic [CNT_W-1:0]   count_upd;
    logic [SWEEP_W-1:0] eff_len;
    logic               upd_wr_en;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic               mem_wr_data;

    assign adv        = !result_valid_reg || result_ready;
    assign site_ready = !clr_active_reg && (!s1_valid_reg || adv);
    assign accept     = site_valid && site_ready;
    assign s1_fire    = s1_valid_reg && adv;

    lcpu_lattice_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_en     (accept),
        .rd_addr_a (here_addr),
        .rd_addr_b (nb_addr),
        .rd_data_a (rd_here),
        .rd_data_b (rd_nb)
    );

    always_comb
    begin
        if (cfg.sweep_length == '0)
            eff_len = SWEEP_W'(1);
        else if (cfg.sweep_length > SWEEP_MAX)
            eff_len = SWEEP_MAX;
        else
            eff_len = cfg.sweep_length;
    end

    always_comb
    begin
        if (s1_ctr_reg.hit)
            cur_here = centre_reg[s1_ctr_reg.idx];
        else if (s1_fwd_here_reg)
            cur_here = s1_fwd_here_val_reg;
        else
            cur_here = rd_here;

        if (s1_nb_ctr_reg.hit)
            cur_nb = centre_reg[s1_nb_ctr_reg.idx];
        else if (s1_fwd_nb_reg)
            cur_nb = s1_fwd_nb_val_reg;
        else
            cur_nb = rd_nb;

        die  = cur_here && ({1'b0, s1_frac_reg} < cfg.death_threshold);
        grow = !cur_here && cur_nb && ({1'b0, s1_frac_reg} < cfg.growth_threshold);
        new_val = (cur_here && !die) || grow;

        count_upd = count_reg - CNT_W'(die) + CNT_W'(grow);
        sweep_end = (SWEEP_W'(sweep_reg) + SWEEP_W'(1)) >= eff_len;
        reseed    = sweep_end && (count_upd == '0);

        count_next = reseed ? CNT_W'(SEED_COUNT) : count_upd;
        sweep_next = sweep_end ? '0 : sweep_reg + SWEEP_CNT_W'(1);
        total_next = reseed ? total_reg + TOTAL_W'(1) : total_reg;

        centre_next = centre_reg;
        if (reseed)
            centre_next = '1;
        else if (s1_ctr_reg.hit)
            centre_next[s1_ctr_reg.idx] = new_val;

        upd_wr_en = s1_fire && !s1_ctr_reg.hit && (die || grow);
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_reg;
            mem_wr_data = 1'b0;
        end
        else
        begin
            mem_wr_en   = upd_wr_en;
            mem_wr_addr = s1_addr_reg;
            mem_wr_data = new_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= CNT_W'(SEED_COUNT);
            sweep_reg        <= '0;
            total_reg        <= '0;
            centre_reg       <= '1;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1))
                    clr_active_reg <= 1'b0;
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                result_valid_reg <= 1'b1;
                count_reg        <= count_next;
                sweep_reg        <= sweep_next;
                total_reg        <= total_next;
                centre_reg       <= centre_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // write of the item leaving the update stage is caught here, since the
    // memory read of the same edge returns the old bit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg         <= here_addr;
            s1_ctr_reg          <= here_ctr;
            s1_nb_ctr_reg       <= nb_ctr;
            s1_frac_reg         <= site_item.random_fraction;
            s1_fwd_here_reg     <= upd_wr_en && (s1_addr_reg == here_addr);
            s1_fwd_here_val_reg <= new_val;
            s1_fwd_nb_reg       <= upd_wr_en && (s1_addr_reg == nb_addr);
            s1_fwd_nb_val_reg   <= new_val;
        end
        if (s1_fire)
        begin
            result_reg.new_value   <= new_val;
            result_reg.population  <= POP_W'(count_next);
            result_reg.sweep_end   <= sweep_end;
            result_reg.reseeded    <= reseed;
            result_reg.reset_total <= total_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule
